// ===== rtl/mmar_pkg.sv =====
// shared types and constants for the masked matrix axis reduction
// no dependencies
package mmar_pkg;
  localparam int MAX_DIM   = 1024;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = IDX_W + 1;
  localparam int ACC_WIDTH = 48;
  localparam int OUT_W     = 48;
  localparam int SAMPLE_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;
  localparam int DIV_STEPS = ACC_WIDTH;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_FRONT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USE_LENGTHS  = 3'd4;

  localparam logic [1:0] OP_SUM  = 2'd0;
  localparam logic [1:0] OP_MEAN = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input beat
    logic exec;      // combine and step position
    logic div_start;
    logic div_step;
    logic out_load;  // load output register from result
    logic restart;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_len;
    logic emit;
    logic need_div;
    logic div_done;
  } stat_t;
endpackage

// ===== rtl/masked_matrix_axis_reduce.sv =====
// top level of the masked matrix axis reduction
// depends on mmar_pkg, mmar_ctrl, mmar_dp
//
// Input channel in_*: valid/ready beats. kind 0 loads a segment length
// (column in front mode, row in back mode), kind 1 is a Q16.16 sample of
// the matrix in row-major order. Output channel out_*: one result beat
// per finished segment, with its index and a last flag on the matrix end.
// cfg_*: plain write port; registers are to be written only while idle,
// which the block itself does not enforce; any write restarts the matrix
// position. Each beat passes through capture, memory read and combine; a
// beat that ends a segment then loads the output register, after the
// one-bit-a-step divider in mean mode. The controller takes a new beat
// only in its idle state, so no beat is accepted before the last is done.
// Reset clears configuration to defaults and position to zero; memory
// contents are undefined until written. When the receiver stalls, the
// held result waits in the output register and beats keep flowing until
// the next segment result is ready; that result then holds the input off
// until the output register drains.
module masked_matrix_axis_reduce (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mmar_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmar_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [mmar_pkg::IDX_W-1:0]           in_length_index,
  input  logic [mmar_pkg::DIM_W-1:0]           in_length_value,
  input  logic signed [mmar_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mmar_pkg::OUT_W-1:0]    out_result_value,
  output logic [mmar_pkg::IDX_W-1:0]           out_result_index,
  output logic                                 out_last_result
);
  import mmar_pkg::*;
  cmd_t  cmd;
  stat_t st;

  // controller
  mmar_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready),
    .out_busy(out_valid && !out_ready), .cfg_we(cfg_we), .st(st),
    .in_ready(in_ready), .cmd(cmd));

  // datapath
  mmar_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .in_kind(in_kind),
    .in_length_index(in_length_index), .in_length_value(in_length_value),
    .in_sample(in_sample), .out_ready(out_ready), .out_valid(out_valid),
    .out_result_value(out_result_value), .out_result_index(out_result_index),
    .out_last_result(out_last_result));
endmodule

// ===== rtl/mmar_ram.sv =====
// generic single port ram with registered read
// no dependencies
module mmar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read; a read of the address being written gives the old data
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/mmar_ctrl.sv =====
// controller state machine for the reduction
// depends on mmar_pkg
module mmar_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_busy,
  input  logic           cfg_we,
  input  mmar_pkg::stat_t st,
  output logic           in_ready,
  output mmar_pkg::cmd_t cmd
);
  import mmar_pkg::*;
  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.restart = cfg_we;
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (st.is_len || !st.emit) state_nxt = ST_IDLE;
        else if (st.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else state_nxt = ST_OUT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/mmar_dp.sv =====
// datapath: config registers, memories, accumulate, divider, output register
// depends on mmar_pkg and mmar_ram
module mmar_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mmar_pkg::cmd_t                    cmd,
  output mmar_pkg::stat_t                   st,
  input  logic                              cfg_we,
  input  logic [mmar_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmar_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                              in_kind,
  input  logic [mmar_pkg::IDX_W-1:0]        in_length_index,
  input  logic [mmar_pkg::DIM_W-1:0]        in_length_value,
  input  logic signed [mmar_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [mmar_pkg::OUT_W-1:0] out_result_value,
  output logic [mmar_pkg::IDX_W-1:0]        out_result_index,
  output logic                              out_last_result
);
  import mmar_pkg::*;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // configuration registers
  logic             front_r;
  logic [1:0]       op_r;
  logic [DIM_W-1:0] rows_cfg_r, cols_cfg_r;
  logic             use_len_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= 1'b0; op_r <= OP_SUM; rows_cfg_r <= DIM_W'(1);
      cols_cfg_r <= DIM_W'(1); use_len_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REDUCE_FRONT: front_r    <= cfg_data[0];
        REG_OP_MODE:      op_r       <= cfg_data[1:0];
        REG_ROW_COUNT:    rows_cfg_r <= cfg_data[DIM_W-1:0];
        REG_COL_COUNT:    cols_cfg_r <= cfg_data[DIM_W-1:0];
        REG_USE_LENGTHS:  use_len_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction

  logic [DIM_W-1:0] rows, cols;
  assign rows = eff_dim(rows_cfg_r);
  assign cols = eff_dim(cols_cfg_r);

  // captured beat
  logic                       kind_r;
  logic [IDX_W-1:0]           lidx_r;
  logic [DIM_W-1:0]           lval_r;
  logic signed [SAMPLE_W-1:0] samp_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind; lidx_r <= in_length_index;
      lval_r <= in_length_value; samp_r <= in_sample;
    end
  end

  // stream position
  logic [IDX_W-1:0] row_r, col_r;
  logic [DIM_W-1:0] r_e, c_e;
  assign r_e = ({1'b0, row_r} >= rows) ? '0 : {1'b0, row_r};
  assign c_e = ({1'b0, col_r} >= cols) ? '0 : {1'b0, col_r};

  // memories: lengths and column accumulators
  logic [IDX_W-1:0] seg, len_addr;
  logic [DIM_W-1:0] len_rd;
  logic [ACC_WIDTH-1:0] col_rd;
  logic col_we;
  logic signed [ACC_WIDTH-1:0] new_acc;
  assign seg = front_r ? c_e[IDX_W-1:0] : r_e[IDX_W-1:0];
  assign len_addr = cmd.capture ? in_length_index : seg;
  mmar_ram #(.WIDTH(DIM_W), .DEPTH(MAX_DIM)) u_len (
    .clk(clk), .we(cmd.capture && !in_kind), .addr(len_addr),
    .wdata(in_length_value), .rdata(len_rd));
  mmar_ram #(.WIDTH(ACC_WIDTH), .DEPTH(MAX_DIM)) u_col (
    .clk(clk), .we(col_we), .addr(c_e[IDX_W-1:0]),
    .wdata(new_acc), .rdata(col_rd));

  // segment length and accumulate
  logic [DIM_W-1:0] dim, len;
  logic [DIM_W-1:0] pos;
  logic signed [ACC_WIDTH-1:0] acc_old, row_acc_r, sx, sum;
  logic is_first, counts, emit, last;
  logic signed [ACC_WIDTH:0] wide;
  always_comb begin
    dim = front_r ? rows : cols;
    pos = front_r ? r_e : c_e;
    len = dim;
    if (use_len_r) begin
      len = (len_rd == '0) ? DIM_W'(1) : len_rd;
      if (len > dim) len = dim;
    end
    acc_old = front_r ? $signed(col_rd) : row_acc_r;
    sx = ACC_WIDTH'(samp_r);
    wide = {acc_old[ACC_WIDTH-1], acc_old} + {sx[ACC_WIDTH-1], sx};
    if (wide[ACC_WIDTH] != wide[ACC_WIDTH-1])
      sum = wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    else sum = wide[ACC_WIDTH-1:0];
    is_first = (pos == '0);
    counts = pos < len;
    if (is_first) new_acc = sx;
    else if (!counts) new_acc = acc_old;
    else if (op_r == OP_SUM || op_r == OP_MEAN) new_acc = sum;
    else new_acc = (sx > acc_old) ? sx : acc_old;
    emit = (pos == dim - DIM_W'(1));
    last = (r_e == rows - DIM_W'(1)) && (c_e == cols - DIM_W'(1));
  end
  assign col_we = cmd.exec && !kind_r ? 1'b0 : (cmd.exec && front_r);

  // result staging
  logic signed [ACC_WIDTH-1:0] res_r;
  logic [IDX_W-1:0] res_idx_r;
  logic res_last_r;
  // divider: restoring on magnitude, one bit a step
  logic [ACC_WIDTH-1:0] quo_r;
  logic [DIM_W:0]       rem_r;
  logic [DIM_W-1:0]     dvs_r;
  logic                 neg_r;
  logic [STEP_W-1:0]    step_r;
  logic [DIM_W:0]       trial;
  assign trial = {rem_r[DIM_W-1:0], quo_r[ACC_WIDTH-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; col_r <= '0; row_acc_r <= '0; step_r <= '0;
    end else if (cmd.restart) begin
      row_r <= '0; col_r <= '0; row_acc_r <= '0;
    end else begin
      if (cmd.exec && kind_r) begin
        if (!front_r) row_acc_r <= new_acc;
        res_r <= new_acc; res_idx_r <= seg; res_last_r <= last;
        if (c_e == cols - DIM_W'(1)) begin
          col_r <= '0;
          row_r <= (r_e == rows - DIM_W'(1)) ? '0 : IDX_W'(r_e + DIM_W'(1));
        end else begin
          col_r <= IDX_W'(c_e + DIM_W'(1)); row_r <= r_e[IDX_W-1:0];
        end
      end
      if (cmd.div_start) begin
        neg_r <= new_acc[ACC_WIDTH-1];
        quo_r <= new_acc[ACC_WIDTH-1] ? -new_acc : new_acc;
        rem_r <= '0; dvs_r <= len; step_r <= STEP_W'(DIV_STEPS);
      end else if (cmd.div_step && step_r != '0) begin
        if (!trial[DIM_W]) begin
          rem_r <= trial; quo_r <= {quo_r[ACC_WIDTH-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DIM_W-1:0], quo_r[ACC_WIDTH-1]};
          quo_r <= {quo_r[ACC_WIDTH-2:0], 1'b0};
        end
        step_r <= step_r - STEP_W'(1);
      end else if (cmd.div_step) begin
        res_r <= neg_r ? -$signed(quo_r) : $signed(quo_r);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_value <= res_r; out_result_index <= res_idx_r;
      out_last_result <= res_last_r;
    end
  end

  assign st.is_len   = !kind_r;
  assign st.emit     = emit;
  assign st.need_div = (op_r == OP_MEAN);
  assign st.div_done = cmd.div_step && (step_r == '0);
endmodule

// ===== rtl/mmar_checker.sv =====
// port-level checks for the masked matrix axis reduction
// depends on masked_matrix_axis_reduce ports
module mmar_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_kind,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_result
);
  // ready drops after accepting a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
  // out_valid is still low at the checked point after a length beat is accepted with the output empty
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind && !out_valid |-> ##3 !out_valid)
    else $error("result from length beat");
  // held result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last_result))
    else $error("result dropped");
  // out_valid quiet after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind masked_matrix_axis_reduce mmar_checker u_mmar_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_kind(in_kind), .out_valid(out_valid), .out_ready(out_ready),
  .out_last_result(out_last_result));

// ===== bench/tb_masked_matrix_axis_reduce.sv =====
// testbench for the masked matrix axis reduction: directed table, directed corner cases, then random matrices
// depends on mmar_pkg and masked_matrix_axis_reduce
module tb_masked_matrix_axis_reduce;
  timeunit 1ns;
  timeprecision 1ps;
  import mmar_pkg::*;

  typedef struct packed {
    logic                       kind;
    logic [IDX_W-1:0]           len_idx;
    logic [DIM_W-1:0]           len_val;
    logic signed [SAMPLE_W-1:0] smp;
  } beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    last;
  } result_t;

  localparam logic KIND_LEN = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam logic [1:0] OP_MAX = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint SUM_HI = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [IDX_W-1:0] in_length_index = '0;
  logic [DIM_W-1:0] in_length_value = '0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_result_value;
  logic [IDX_W-1:0] out_result_index;
  logic out_last_result;

  masked_matrix_axis_reduce dut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic         m_front;
  logic [1:0]   m_op;
  logic [10:0]  m_rows_reg, m_cols_reg;
  logic         m_use_len;
  longint       col_sum [MAX_DIM];
  logic [10:0]  seg_len [MAX_DIM];
  longint       row_sum;
  int           pos_r, pos_c;

  result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int beats_sent = 0;
  bit hold_off = 1'b0;

  function automatic int clamp_dim(logic [10:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > SUM_HI - b) return SUM_HI;
    if (b < 0 && a < SUM_LO - b) return SUM_LO;
    return a + b;
  endfunction

  function automatic longint fold(longint a, longint b);
    if (m_op == OP_SUM || m_op == OP_MEAN) return add_sat(a, b);
    return (b > a) ? b : a;
  endfunction

  function automatic int counted_len(int seg, int dim);
    int n;
    if (!m_use_len) return dim;
    n = seg_len[seg];
    if (n == 0) n = 1;
    if (n > dim) n = dim;
    return n;
  endfunction

  // mirror of the block for one accepted beat; queues a result when a segment ends
  task automatic predict_reduction(input beat_t b);
    int rows, cols, n;
    longint s, v;
    result_t res;
    bit emit;
    rows = clamp_dim(m_rows_reg);
    cols = clamp_dim(m_cols_reg);
    emit = 1'b0;
    if (b.kind == KIND_LEN) begin
      seg_len[b.len_idx] = b.len_val;
      return;
    end
    s = longint'(b.smp);
    if (pos_r >= rows) pos_r = 0;
    if (pos_c >= cols) pos_c = 0;
    res.last = (pos_r == rows - 1) && (pos_c == cols - 1);
    if (m_front) begin
      n = counted_len(pos_c, rows);
      if (pos_r == 0) col_sum[pos_c] = s;
      else if (pos_r < n) col_sum[pos_c] = fold(col_sum[pos_c], s);
      if (pos_r == rows - 1) begin
        emit = 1'b1;
        res.index = pos_c;
        v = col_sum[pos_c];
      end
    end else begin
      n = counted_len(pos_r, cols);
      if (pos_c == 0) row_sum = s;
      else if (pos_c < n) row_sum = fold(row_sum, s);
      if (pos_c == cols - 1) begin
        emit = 1'b1;
        res.index = pos_r;
        v = row_sum;
      end
    end
    if (emit) begin
      if (m_op == OP_MEAN) v = v / n;
      res.value = v[OUT_W-1:0];
      pending_results.insert(pending_results.size(), res);
    end
    pos_c++;
    if (pos_c == cols) begin
      pos_c = 0;
      pos_r++;
      if (pos_r == rows) pos_r = 0;
    end
  endtask

  // one register write; the caller drops the write enable after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DAT_W-1:0];
    @(posedge clk);
    case (idx)
      REG_REDUCE_FRONT: m_front = val[0];
      REG_OP_MODE:      m_op = val[1:0];
      REG_ROW_COUNT:    m_rows_reg = val[10:0];
      REG_COL_COUNT:    m_cols_reg = val[10:0];
      REG_USE_LENGTHS:  m_use_len = val[0];
      default: ;
    endcase
    pos_r = 0;
    pos_c = 0;
    row_sum = 0;
  endtask

  // wait until every expected result is out, then let the block settle
  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // configuration only once the block is idle
  task automatic setup(input int front, input int op, input int rows, input int cols,
                       input int use_len);
    drain();
    write_reg(REG_REDUCE_FRONT, front);
    write_reg(REG_OP_MODE, op);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_USE_LENGTHS, use_len);
    cfg_we <= 1'b0;
  endtask

  // hand one beat to the block, with an optional random gap ahead of it
  task automatic send_beat(input beat_t b, input bit gaps);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40) :
                     $urandom_range(1, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= b.kind;
    in_length_index <= b.len_idx;
    in_length_value <= b.len_val;
    in_sample <= b.smp;
    do @(posedge clk); while (!in_ready);
    predict_reduction(b);
    beats_sent++;
  endtask

  function automatic beat_t sample_beat(longint v);
    beat_t b;
    b = '0;
    b.kind = KIND_SAMPLE;
    b.smp = v[31:0];
    return b;
  endfunction

  function automatic beat_t len_beat(int idx, int val);
    beat_t b;
    b = '0;
    b.kind = KIND_LEN;
    b.len_idx = idx;
    b.len_val = val;
    b.smp = $urandom;
    return b;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result value=%0d index=%0d", $time,
                 out_result_value, out_result_index);
        errors++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (out_result_value !== e.value) begin
          $display("%0t value mismatch: expected %0d actual %0d", $time, e.value,
                   out_result_value);
          errors++;
        end
        if (out_result_index !== e.index) begin
          $display("%0t index mismatch: expected %0d actual %0d", $time, e.index,
                   out_result_index);
          errors++;
        end
        if (out_last_result !== e.last) begin
          $display("%0t last mismatch: expected %0b actual %0b", $time, e.last,
                   out_last_result);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 19) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3));
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end
    end
  end

  // overall time limit
  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

  // directed table: beats plus a known result where one is read off at a glance
  typedef struct {
    beat_t   b;
    bit      known;
    result_t res;
  } row_t;

  initial begin
    row_t tbl[$];
    row_t r;
    int rows, cols, nmat, k, i, reps;
    for (i = 0; i < MAX_DIM; i++) begin
      col_sum[i] = 0;
      seg_len[i] = 0;
    end
    m_front = 0; m_op = OP_SUM; m_rows_reg = 1; m_cols_reg = 1; m_use_len = 0;
    pos_r = 0; pos_c = 0; row_sum = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset a 1x1 sum passes the sample through
    r.known = 1; r.b = sample_beat(32'h7fffffff);
    r.res = '{value: 48'sh00007fffffff, index: 0, last: 1};
    tbl.insert(tbl.size(), r);
    r.b = sample_beat(-64'sd2147483648);
    r.res = '{value: -48'sd2147483648, index: 0, last: 1};
    tbl.insert(tbl.size(), r);
    r.known = 0; r.b = sample_beat(0);
    tbl.insert(tbl.size(), r);
    foreach (tbl[j]) begin
      send_beat(tbl[j].b, 0);
      if (tbl[j].known && pending_results.size() != 0 &&
          pending_results[$] !== tbl[j].res) begin
        $display("%0t table row %0d: expected %0d predicted %0d", $time, j,
                 tbl[j].res.value, pending_results[$].value);
        errors++;
      end
    end
    drain();

    // every op, both modes, lengths zero, mid and oversized, extreme samples
    for (k = 0; k < 8; k++) begin
      setup(k[0], (k >> 1), 2, 3, 1);
      send_beat(len_beat(0, 0), 1);
      send_beat(len_beat(1, 2047), 1);
      send_beat(len_beat(2, 2), 1);
      for (i = 0; i < 6; i++)
        send_beat(sample_beat(i[0] ? 32'h7fffffff : 32'h80000001 + i), 1);
    end

    // long rows of extreme samples, both signs, back to back
    setup(0, OP_SUM, 1, 64, 0);
    for (i = 0; i < 64; i++) send_beat(sample_beat(32'h7fffffff), 0);
    setup(0, OP_MEAN, 1, 64, 0);
    for (i = 0; i < 64; i++) send_beat(sample_beat(32'h80000000), 0);
    // row count of 0 and oversized column count, then an oversized row count
    setup(1, OP_MAX, 0, 2047, 0);
    for (i = 0; i < 40; i++) send_beat(sample_beat(rand_sample()), 0);
    setup(0, OP_UNUSED, 2047, 1, 0);
    for (i = 0; i < 40; i++) send_beat(sample_beat(rand_sample()), 0);
    // length entries at the top of the index range, then a short masked mean
    setup(0, OP_SUM, 2, 1, 1);
    send_beat(len_beat(1023, 1024), 1);
    send_beat(len_beat(1022, 1), 1);
    setup(0, OP_MEAN, 3, 4, 1);
    for (i = 0; i < 3; i++) send_beat(len_beat(i, $urandom_range(0, 5)), 0);
    for (i = 0; i < 12; i++) send_beat(sample_beat(rand_sample()), 0);
    drain();

    // random matrices, small sizes; with lengths in use, lengths loaded for every segment first
    nmat = 0;
    while (beats_sent < 800) begin
      int front, use_len, nseg;
      front = $urandom_range(0, 1);
      use_len = $urandom_range(0, 1);
      rows = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
      cols = (rows > 6) ? $urandom_range(0, 3) :
             (($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6));
      setup(front, $urandom_range(0, 3), rows, cols, use_len);
      rows = clamp_dim(rows);
      cols = clamp_dim(cols);
      nseg = front ? cols : rows;
      reps = (rows * cols > 36) ? 1 : $urandom_range(1, 3);
      if (use_len)
        for (i = 0; i < nseg; i++)
          send_beat(len_beat(i, ($urandom_range(0, 4) == 0) ?
                             $urandom_range(0, 2047) :
                             $urandom_range(0, (front ? rows : cols) + 1)), 1);
      if (nmat == 3) hold_off = 1'b1;
      for (k = 0; k < reps; k++)
        for (i = 0; i < rows * cols; i++) begin
          // occasional stray length reload of an already-written entry
          if (use_len && $urandom_range(0, 15) == 0)
            send_beat(len_beat($urandom_range(0, nseg - 1), $urandom_range(0, 8)), 1);
          send_beat(sample_beat(rand_sample()), 1);
        end
      drain();
      nmat++;
    end

    $display("covered %0d input beats over %0d random matrices, %0d results checked",
             beats_sent, nmat, results_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
